// File: hdl/wbt_pkg.sv
// wbt_pkg: shared types, constants and helpers for the word-break tokenizer
// used by the channel interfaces, the rule core, the token queue and the top level
// depends on nothing

package wbt_pkg;

    // position counters and output field widths
    localparam int POS_W   = 24;
    localparam int OUT_W   = 24;
    localparam int CLASS_W = 4;
    localparam int BCNT_W  = 3;

    // token queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [OUT_W-1:0]   t_out;
    typedef logic [CLASS_W-1:0] t_cls;
    typedef logic [BCNT_W-1:0]  t_bcnt;
    typedef logic [CNT_W-1:0]   t_cnt;

    localparam t_pos POS_MAX = {POS_W{1'b1}};

    // break classes
    localparam t_cls CLS_OTHER     = 4'd0;
    localparam t_cls CLS_SINGLE    = 4'd1;
    localparam t_cls CLS_LETTER    = 4'd2;
    localparam t_cls CLS_HEBREW    = 4'd3;
    localparam t_cls CLS_NUMERIC   = 4'd4;
    localparam t_cls CLS_KATAKANA  = 4'd5;
    localparam t_cls CLS_EXTNUMLET = 4'd6;
    localparam t_cls CLS_EXTEND    = 4'd7;
    localparam t_cls CLS_SQUOTE    = 4'd8;
    localparam t_cls CLS_DQUOTE    = 4'd9;
    localparam t_cls CLS_MIDNUMLET = 4'd10;
    localparam t_cls CLS_MIDLETTER = 4'd11;
    localparam t_cls CLS_MIDNUM    = 4'd12;
    localparam t_cls CLS_NONE      = 4'd0;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_WORD   = 3'b010,
        MODE_SINGLE = 3'b100
    } t_mode;

    typedef struct packed {
        t_out start_byte;
        t_out byte_length;
        t_out start_char;
        t_out end_char;
        logic last;
    } t_token;

    // up to two tokens from one code point, first one closed by a break
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token tok0;
        t_token tok1;
    } t_push;

    typedef struct packed {
        logic idle;
        logic in_word;
        logic pending;
    } t_core_status;

    typedef struct packed {
        t_cnt count;
        logic room;
    } t_fifo_status;

    function automatic t_pos sat_add(t_pos a, t_bcnt b);
        logic [POS_W:0] s;
        s = (POS_W+1)'(a) + (POS_W+1)'(b);
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

endpackage

// File: hdl/wbt_if.sv
// wbt_in_if / wbt_out_if: valid/ready channels for code points and token spans
// depends on wbt_pkg

interface wbt_in_if;
    logic                valid;
    logic                ready;
    wbt_pkg::t_cls       word_class;
    wbt_pkg::t_bcnt      byte_count;
    logic                end_of_text;

    modport source (output valid, output word_class, output byte_count,
                    output end_of_text, input ready);
    modport sink   (input valid, input word_class, input byte_count,
                    input end_of_text, output ready);
endinterface

interface wbt_out_if;
    logic                valid;
    logic                ready;
    wbt_pkg::t_out       token_start_byte;
    wbt_pkg::t_out       token_byte_length;
    wbt_pkg::t_out       token_start_char;
    wbt_pkg::t_out       token_end_char;
    logic                last_of_run;

    modport source (output valid, output token_start_byte, output token_byte_length,
                    output token_start_char, output token_end_char,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_start_byte, input token_byte_length,
                    input token_start_char, input token_end_char,
                    input last_of_run, output ready);
endinterface

// File: hdl/wbt_core.sv
// wbt_core: word-break rule state and position counters, one code point per transfer
// depends on wbt_pkg

module wbt_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  wbt_pkg::t_cls         i_word_class,
    input  wbt_pkg::t_bcnt        i_byte_count,
    input  logic                  i_end_of_text,
    output wbt_pkg::t_push        o_push,
    output wbt_pkg::t_core_status o_status
);

    wbt_pkg::t_mode r_mode, n_mode;
    wbt_pkg::t_cls  r_wsc, n_wsc;
    wbt_pkg::t_cls  r_pend, n_pend;
    wbt_pkg::t_pos  r_bpos, n_bpos;
    wbt_pkg::t_pos  r_cpos, n_cpos;
    wbt_pkg::t_pos  r_sb, n_sb;
    wbt_pkg::t_pos  r_sc, n_sc;
    wbt_pkg::t_pos  r_eb, n_eb;
    wbt_pkg::t_pos  r_ec, n_ec;

    function automatic wbt_pkg::t_token make_tok(wbt_pkg::t_pos sb, wbt_pkg::t_pos eb,
                                                 wbt_pkg::t_pos sc, wbt_pkg::t_pos ec,
                                                 logic last);
        wbt_pkg::t_token t;
        wbt_pkg::t_pos   len;
        len           = eb - sb;
        t.start_byte  = wbt_pkg::OUT_W'(sb);
        t.byte_length = wbt_pkg::OUT_W'(len);
        t.start_char  = wbt_pkg::OUT_W'(sc);
        t.end_char    = wbt_pkg::OUT_W'(ec);
        t.last        = last;
        return t;
    endfunction

    wbt_pkg::t_cls cls;
    wbt_pkg::t_pos nb, nc;
    logic          acc, brk, start_new, emit1;

    always_comb begin
        cls       = (i_word_class > wbt_pkg::CLS_MIDNUM) ? wbt_pkg::CLS_OTHER : i_word_class;
        nb        = wbt_pkg::sat_add(r_bpos, i_byte_count);
        nc        = wbt_pkg::sat_add(r_cpos, wbt_pkg::t_bcnt'(1));
        acc       = 1'b0;
        brk       = 1'b0;
        start_new = 1'b0;
        n_mode    = r_mode;
        n_wsc     = r_wsc;
        n_pend    = r_pend;
        n_sb      = r_sb;
        n_sc      = r_sc;
        n_eb      = r_eb;
        n_ec      = r_ec;

        unique case (r_mode)
            wbt_pkg::MODE_SINGLE: begin
                if (cls == wbt_pkg::CLS_EXTEND) begin
                    n_eb = nb;
                    n_ec = nc;
                end else begin
                    brk = 1'b1;
                end
            end
            wbt_pkg::MODE_WORD: begin
                if (r_pend != wbt_pkg::CLS_NONE) begin
                    // pending punctuation resolved by the next non-extend character
                    if (cls != wbt_pkg::CLS_EXTEND) begin
                        if (r_pend == wbt_pkg::CLS_DQUOTE)
                            acc = (cls == wbt_pkg::CLS_HEBREW);
                        else if (r_wsc == wbt_pkg::CLS_LETTER || r_wsc == wbt_pkg::CLS_HEBREW)
                            acc = (cls == wbt_pkg::CLS_LETTER || cls == wbt_pkg::CLS_HEBREW);
                        else if (r_wsc == wbt_pkg::CLS_NUMERIC)
                            acc = (cls == wbt_pkg::CLS_NUMERIC);
                        n_pend = wbt_pkg::CLS_NONE;
                        brk    = !acc;
                    end
                end else begin
                    unique case (cls)
                        wbt_pkg::CLS_LETTER, wbt_pkg::CLS_HEBREW, wbt_pkg::CLS_NUMERIC: begin
                            if (r_wsc == wbt_pkg::CLS_KATAKANA) brk = 1'b1;
                            else acc = 1'b1;
                        end
                        wbt_pkg::CLS_KATAKANA: begin
                            if (r_wsc != wbt_pkg::CLS_KATAKANA &&
                                r_wsc != wbt_pkg::CLS_EXTNUMLET) brk = 1'b1;
                            else acc = 1'b1;
                        end
                        wbt_pkg::CLS_EXTNUMLET: acc = 1'b1;
                        wbt_pkg::CLS_EXTEND: begin
                            n_eb = nb;
                            n_ec = nc;
                        end
                        wbt_pkg::CLS_SQUOTE, wbt_pkg::CLS_MIDNUMLET,
                        wbt_pkg::CLS_MIDLETTER, wbt_pkg::CLS_MIDNUM: begin
                            if (r_wsc == wbt_pkg::CLS_LETTER) begin
                                if (cls == wbt_pkg::CLS_MIDNUM) brk = 1'b1;
                                else n_pend = cls;
                            end else if (r_wsc == wbt_pkg::CLS_HEBREW) begin
                                if (cls == wbt_pkg::CLS_MIDNUM) begin
                                    brk = 1'b1;
                                end else begin
                                    // hebrew single quote belongs to the token at once
                                    if (cls == wbt_pkg::CLS_SQUOTE) begin
                                        n_eb = nb;
                                        n_ec = nc;
                                    end
                                    n_pend = cls;
                                end
                            end else if (r_wsc == wbt_pkg::CLS_NUMERIC) begin
                                if (cls == wbt_pkg::CLS_MIDLETTER) brk = 1'b1;
                                else n_pend = cls;
                            end else begin
                                brk = 1'b1;
                            end
                        end
                        wbt_pkg::CLS_DQUOTE: begin
                            if (r_wsc == wbt_pkg::CLS_HEBREW) n_pend = wbt_pkg::CLS_DQUOTE;
                            else brk = 1'b1;
                        end
                        default: brk = 1'b1;
                    endcase
                end
                if (acc) begin
                    n_wsc = cls;
                    n_eb  = nb;
                    n_ec  = nc;
                end
            end
            default: start_new = 1'b1;
        endcase

        if (brk) begin
            n_mode    = wbt_pkg::MODE_IDLE;
            n_pend    = wbt_pkg::CLS_NONE;
            start_new = 1'b1;
        end

        if (start_new && cls >= wbt_pkg::CLS_SINGLE && cls <= wbt_pkg::CLS_EXTNUMLET) begin
            n_mode = (cls == wbt_pkg::CLS_SINGLE) ? wbt_pkg::MODE_SINGLE : wbt_pkg::MODE_WORD;
            n_wsc  = cls;
            n_pend = wbt_pkg::CLS_NONE;
            n_sb   = r_bpos;
            n_sc   = r_cpos;
            n_eb   = nb;
            n_ec   = nc;
        end

        n_bpos = nb;
        n_cpos = nc;

        emit1 = i_end_of_text && (n_mode != wbt_pkg::MODE_IDLE);

        // tokens: the closed word uses the old span, the end-of-text one the new span
        o_push.v0   = i_accept && brk;
        o_push.v1   = i_accept && emit1;
        o_push.tok0 = make_tok(r_sb, r_eb, r_sc, r_ec, !emit1);
        o_push.tok1 = make_tok(n_sb, n_eb, n_sc, n_ec, 1'b1);

        if (i_end_of_text) begin
            n_mode = wbt_pkg::MODE_IDLE;
            n_wsc  = wbt_pkg::CLS_NONE;
            n_pend = wbt_pkg::CLS_NONE;
            n_bpos = '0;
            n_cpos = '0;
            n_sb   = '0;
            n_sc   = '0;
            n_eb   = '0;
            n_ec   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= wbt_pkg::MODE_IDLE;
            r_wsc  <= wbt_pkg::CLS_NONE;
            r_pend <= wbt_pkg::CLS_NONE;
            r_bpos <= '0;
            r_cpos <= '0;
            r_sb   <= '0;
            r_sc   <= '0;
            r_eb   <= '0;
            r_ec   <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_wsc  <= n_wsc;
            r_pend <= n_pend;
            r_bpos <= n_bpos;
            r_cpos <= n_cpos;
            r_sb   <= n_sb;
            r_sc   <= n_sc;
            r_eb   <= n_eb;
            r_ec   <= n_ec;
        end
    end

    assign o_status.idle    = (r_mode == wbt_pkg::MODE_IDLE);
    assign o_status.in_word = (r_mode == wbt_pkg::MODE_WORD);
    assign o_status.pending = (r_pend != wbt_pkg::CLS_NONE);

endmodule

// File: hdl/wbt_fifo.sv
// wbt_fifo: small token queue, takes up to two tokens a cycle and gives one
// depends on wbt_pkg

module wbt_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wbt_pkg::t_push        i_push,
    input  logic                  i_pop,
    output logic                  o_valid,
    output wbt_pkg::t_token       o_head,
    output wbt_pkg::t_fifo_status o_status
);

    wbt_pkg::t_token             r_mem [wbt_pkg::FIFO_DEPTH];
    logic [wbt_pkg::PTR_W-1:0]   r_wr, n_wr;
    logic [wbt_pkg::PTR_W-1:0]   r_rd, n_rd;
    wbt_pkg::t_cnt               r_count, n_count;
    wbt_pkg::t_token             e0;
    logic [1:0]                  npush;
    logic [wbt_pkg::PTR_W-1:0]   wr1;

    always_comb begin
        e0      = i_push.v0 ? i_push.tok0 : i_push.tok1;
        npush   = 2'(i_push.v0) + 2'(i_push.v1);
        wr1     = r_wr + wbt_pkg::PTR_W'(1);
        n_wr    = r_wr + wbt_pkg::PTR_W'(npush);
        n_rd    = i_pop ? r_rd + wbt_pkg::PTR_W'(1) : r_rd;
        n_count = r_count + wbt_pkg::CNT_W'(npush) - wbt_pkg::CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (npush != 2'd0) r_mem[r_wr] <= e0;
        if (npush == 2'd2) r_mem[wr1]  <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_valid        = (r_count != '0);
    assign o_head         = r_mem[r_rd];
    assign o_status.count = r_count;
    // room for the two tokens one code point may produce
    assign o_status.room  = (r_count <= wbt_pkg::CNT_W'(wbt_pkg::FIFO_DEPTH - 2));

endmodule

// File: hdl/unicode_word_break_tokenizer.sv
// unicode_word_break_tokenizer: one code point in per cycle while the token queue has room, token spans out
// each token is written into the token queue and offered on o_out from its head
// throughput: one code point per cycle while the queue has room; a code point that closes a word and ends the
// text yields two tokens, and the output side drains one token per cycle while o_out.ready is high
// reset: synchronous active-low i_rst_n clears rule state, positions and token queue
// depends on wbt_pkg, wbt_if, wbt_core, wbt_fifo

module unicode_word_break_tokenizer (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wbt_in_if.sink    i_in,
    wbt_out_if.source o_out
);

    logic                  in_xfer;
    logic                  out_xfer;
    wbt_pkg::t_push        push;
    wbt_pkg::t_core_status core_st;
    wbt_pkg::t_fifo_status fifo_st;
    wbt_pkg::t_token       head;

    // input is taken only while the queue can absorb a worst-case pair of tokens
    assign i_in.ready = fifo_st.room;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = o_out.valid && o_out.ready;

    // rule evaluation and span bookkeeping, updated once per code point transfer
    wbt_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_word_class  (i_in.word_class),
        .i_byte_count  (i_in.byte_count),
        .i_end_of_text (i_in.end_of_text),
        .o_push        (push),
        .o_status      (core_st)
    );

    // token queue decouples the two sides so input keeps flowing under output stall until the queue runs short of room
    wbt_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (out_xfer),
        .o_valid  (o_out.valid),
        .o_head   (head),
        .o_status (fifo_st)
    );

    assign o_out.token_start_byte  = head.start_byte;
    assign o_out.token_byte_length = head.byte_length;
    assign o_out.token_start_char  = head.start_char;
    assign o_out.token_end_char    = head.end_char;
    assign o_out.last_of_run       = head.last;

    // checks

    // two tokens from one code point only when it ends the text
    a_pair_needs_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.v0 && push.v1) |-> i_in.end_of_text)
        else $error("two tokens without end of text");

    // end of text always leaves the scanner outside any word
    a_eot_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.end_of_text) |=> core_st.idle)
        else $error("scanner not idle after end of text");

    // held punctuation exists only while the scanner is in word mode
    a_pend_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_st.pending |-> core_st.in_word)
        else $error("pending punctuation outside a word");

    // queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_st.count <= wbt_pkg::CNT_W'(wbt_pkg::FIFO_DEPTH))
        else $error("token queue overflow");

    // pushes only happen for an accepted code point
    a_push_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.v0 || push.v1) |-> in_xfer)
        else $error("token pushed without a code point transfer");

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for unicode_word_break_tokenizer, one code point per transfer
// directed table then random text, token spans checked against hand-written typed rows or an in-bench rule predictor
// depends on wbt_pkg, wbt_if and the tokenizer top level

module tb_top;
    import wbt_pkg::*;

    // run length and watchdog
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    // one row of stimulus; typed rows carry their tokens written out by hand
    typedef struct {
        t_cls        cls;
        t_bcnt       bcnt;
        logic        eot;
        bit          typed;
        int unsigned n_typed;
        t_token      t0;
        t_token      t1;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    wbt_in_if  in_if ();
    wbt_out_if out_if ();

    unicode_word_break_tokenizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // token spans still owed by the block, oldest first
    t_token span_q[$];
    t_row   dir_rows[$];

    int unsigned errors;
    int unsigned sent_count;
    int unsigned cycle_count;
    logic        calm;        // no idling on either side while high
    logic        hold_req;    // asks the receiver for one long hold-off

    // predictor state, mirrors the tokenizer's registers
    t_mode scan_st;
    t_cls  word_cls;
    t_cls  held_mid;
    t_pos  cur_bpos, cur_cpos;
    t_pos  tok_sb, tok_sc, tok_eb, tok_ec;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // saturating position counter
    function automatic t_pos pos_step(t_pos p, int unsigned inc);
        logic [POS_W:0] wide;
        wide = {1'b0, p} + (POS_W+1)'(inc);
        return wide[POS_W] ? {POS_W{1'b1}} : wide[POS_W-1:0];
    endfunction

    // span of the open token, as the block reports it
    function automatic t_token open_span();
        return t_token'{start_byte: tok_sb, byte_length: tok_eb - tok_sb,
                        start_char: tok_sc, end_char: tok_ec, last: 1'b0};
    endfunction

    task automatic clear_tokenizer();
        scan_st  = MODE_IDLE;
        word_cls = CLS_NONE;
        held_mid = CLS_NONE;
        cur_bpos = '0;
        cur_cpos = '0;
        tok_sb   = '0;
        tok_sc   = '0;
        tok_eb   = '0;
        tok_ec   = '0;
    endtask

    // applies the break rules to one code point; returns up to two closed spans
    task automatic tokenizer_step(input t_cls c_in, input t_bcnt bcnt, input logic eot,
                                  output t_token s0, output t_token s1, output int ns);
        t_cls c;
        t_pos nb, nc;
        bit   start_new, accept, brk;
        c  = (c_in > CLS_MIDNUM) ? CLS_OTHER : c_in;   // unknown classes act as other
        nb = pos_step(cur_bpos, bcnt);
        nc = pos_step(cur_cpos, 1);
        start_new = 1'b0;
        accept    = 1'b0;
        brk       = 1'b0;
        ns        = 0;
        s0        = '0;
        s1        = '0;

        if (scan_st == MODE_SINGLE) begin
            // single-alpha word soaks up extend/format, anything else closes it
            if (c == CLS_EXTEND) begin
                tok_eb = nb;
                tok_ec = nc;
            end else begin
                s0 = open_span();
                ns = 1;
                scan_st   = MODE_IDLE;
                start_new = 1'b1;
            end
        end else if (scan_st == MODE_WORD) begin
            if (held_mid != CLS_NONE) begin
                // pending middle punctuation: next non-extend char decides
                if (c != CLS_EXTEND) begin
                    if (held_mid == CLS_DQUOTE)
                        accept = (c == CLS_HEBREW);
                    else if (word_cls == CLS_LETTER || word_cls == CLS_HEBREW)
                        accept = (c == CLS_LETTER || c == CLS_HEBREW);
                    else if (word_cls == CLS_NUMERIC)
                        accept = (c == CLS_NUMERIC);
                    held_mid = CLS_NONE;
                    brk = !accept;
                end
            end else begin
                case (c)
                    CLS_LETTER, CLS_HEBREW, CLS_NUMERIC: begin
                        if (word_cls == CLS_KATAKANA) brk = 1'b1;
                        else accept = 1'b1;
                    end
                    CLS_KATAKANA: begin
                        if (word_cls != CLS_KATAKANA && word_cls != CLS_EXTNUMLET) brk = 1'b1;
                        else accept = 1'b1;
                    end
                    CLS_EXTNUMLET: accept = 1'b1;
                    CLS_EXTEND: begin
                        tok_eb = nb;
                        tok_ec = nc;
                    end
                    CLS_SQUOTE, CLS_MIDNUMLET, CLS_MIDLETTER, CLS_MIDNUM: begin
                        if (word_cls == CLS_LETTER) begin
                            if (c == CLS_MIDNUM) brk = 1'b1;
                            else held_mid = c;
                        end else if (word_cls == CLS_HEBREW) begin
                            if (c == CLS_MIDNUM) begin
                                brk = 1'b1;
                            end else begin
                                // hebrew single quote joins the token right away
                                if (c == CLS_SQUOTE) begin
                                    tok_eb = nb;
                                    tok_ec = nc;
                                end
                                held_mid = c;
                            end
                        end else if (word_cls == CLS_NUMERIC) begin
                            if (c == CLS_MIDLETTER) brk = 1'b1;
                            else held_mid = c;
                        end else begin
                            brk = 1'b1;
                        end
                    end
                    CLS_DQUOTE: begin
                        if (word_cls == CLS_HEBREW) held_mid = CLS_DQUOTE;
                        else brk = 1'b1;
                    end
                    default: brk = 1'b1;
                endcase
            end
            if (accept) begin
                word_cls = c;
                tok_eb   = nb;
                tok_ec   = nc;
            end
            if (brk) begin
                s0 = open_span();
                ns = 1;
                scan_st   = MODE_IDLE;
                held_mid  = CLS_NONE;
                start_new = 1'b1;
            end
        end else begin
            start_new = 1'b1;
        end

        // a word-starting class opens a new token at this code point
        if (start_new && c >= CLS_SINGLE && c <= CLS_EXTNUMLET) begin
            scan_st  = (c == CLS_SINGLE) ? MODE_SINGLE : MODE_WORD;
            word_cls = c;
            held_mid = CLS_NONE;
            tok_sb   = cur_bpos;
            tok_sc   = cur_cpos;
            tok_eb   = nb;
            tok_ec   = nc;
        end

        cur_bpos = nb;
        cur_cpos = nc;

        // end of text flushes the open token and rewinds everything
        if (eot) begin
            if (scan_st != MODE_IDLE) begin
                if (ns == 0) s0 = open_span();
                else s1 = open_span();
                ns++;
            end
            clear_tokenizer();
        end

        if (ns == 1) s0.last = 1'b1;
        if (ns == 2) s1.last = 1'b1;
    endtask

    // offers one code point, waits for the transfer, then books the expected spans
    task automatic send_row(input t_row r);
        t_token p0, p1;
        int     np;
        while (!calm && $urandom_range(0, 99) < 11) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.word_class  <= r.cls;
        in_if.byte_count  <= r.bcnt;
        in_if.end_of_text <= r.eot;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        // predictor always advances so that its state tracks the block
        tokenizer_step(r.cls, r.bcnt, r.eot, p0, p1, np);
        if (r.typed) begin
            if (r.n_typed > 0) span_q.push_back(r.t0);
            if (r.n_typed > 1) span_q.push_back(r.t1);
        end else begin
            if (np > 0) span_q.push_back(p0);
            if (np > 1) span_q.push_back(p1);
        end
        sent_count++;
    endtask

    // random code point of a given class; odd byte counts now and then
    task automatic send_random_cp(input t_cls c);
        t_row r;
        r.cls     = c;
        r.bcnt    = ($urandom_range(0, 9) == 0) ? t_bcnt'($urandom_range(0, 7))
                                                : t_bcnt'($urandom_range(1, 4));
        r.eot     = ($urandom_range(0, 39) == 0);
        r.typed   = 1'b0;
        r.n_typed = 0;
        r.t0      = '0;
        r.t1      = '0;
        send_row(r);
    endtask

    // mostly word-shaped runs with punctuation and extend inside, some plain noise
    task automatic send_random_chunk();
        t_cls base;
        int   len;
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 5))
                0:       base = CLS_LETTER;
                1:       base = CLS_HEBREW;
                2:       base = CLS_NUMERIC;
                3:       base = CLS_KATAKANA;
                4:       base = CLS_EXTNUMLET;
                default: base = CLS_SINGLE;
            endcase
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 4) == 0) send_random_cp(t_cls'($urandom_range(1, 6)));
                else send_random_cp(base);
                if ($urandom_range(0, 4) == 0) send_random_cp(CLS_EXTEND);
                if (i < len - 1 && $urandom_range(0, 2) == 0)
                    send_random_cp(t_cls'($urandom_range(8, 12)));
            end
            // separator or whatever comes next
            send_random_cp(t_cls'($urandom_range(0, 15)));
        end else begin
            send_random_cp(t_cls'($urandom_range(0, 15)));
        end
    endtask

    task automatic check_field(input string name, input t_out want, input t_out got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // output monitor: each token transfer against the oldest expectation
    always @(posedge i_clk) begin : token_monitor
        t_token want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (span_q.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual start_byte %0d",
                         $time, out_if.token_start_byte);
                errors++;
            end else begin
                want = span_q.pop_front();
                check_field("token_start_byte", want.start_byte, out_if.token_start_byte);
                check_field("token_byte_length", want.byte_length, out_if.token_byte_length);
                check_field("token_start_char", want.start_char, out_if.token_start_char);
                check_field("token_end_char", want.end_char, out_if.token_end_char);
                check_field("last_of_run", t_out'(want.last), t_out'(out_if.last_of_run));
            end
        end
    end

    // receiver: random backpressure, one long hold-off to fill the token queue
    initial begin : token_sink
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held_once) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // directed table: after reset, two-token item, hebrew quotes, mid punctuation,
    // katakana breaks, single alpha with extend, unknown class, odd byte counts,
    // punctuation left pending at end of text
    task automatic add_row(input t_cls c, input t_bcnt b, input logic e);
        dir_rows.push_back(t_row'{c, b, e, 1'b0, 0, '0, '0});
    endtask

    initial begin : stimulus
        errors      = 0;
        sent_count  = 0;
        cycle_count = 0;
        calm        <= 1'b0;
        hold_req    <= 1'b0;
        clear_tokenizer();

        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.word_class  <= CLS_OTHER;
        in_if.byte_count  <= 3'd1;
        in_if.end_of_text <= 1'b0;

        // typed rows right after reset, positions easy to follow by hand
        add_row(CLS_LETTER, 3'd1, 1'b0);
        add_row(CLS_LETTER, 3'd4, 1'b0);
        dir_rows.push_back(t_row'{CLS_OTHER, 3'd1, 1'b0, 1'b1, 1,
                                  t_token'{24'd0, 24'd5, 24'd0, 24'd2, 1'b1}, '0});
        dir_rows.push_back(t_row'{CLS_SINGLE, 3'd3, 1'b1, 1'b1, 1,
                                  t_token'{24'd6, 24'd3, 24'd3, 24'd4, 1'b1}, '0});
        add_row(CLS_LETTER, 3'd2, 1'b0);
        // letter word closed by katakana, which then ends the text: two tokens
        dir_rows.push_back(t_row'{CLS_KATAKANA, 3'd3, 1'b1, 1'b1, 2,
                                  t_token'{24'd0, 24'd2, 24'd0, 24'd1, 1'b0},
                                  t_token'{24'd2, 24'd3, 24'd1, 24'd2, 1'b1}});
        // hebrew single quote kept at end of text
        add_row(CLS_HEBREW, 3'd2, 1'b0);
        add_row(CLS_SQUOTE, 3'd1, 1'b1);
        // hebrew double quote hebrew, extend, midletter with extend while pending
        add_row(CLS_HEBREW, 3'd2, 1'b0);
        add_row(CLS_DQUOTE, 3'd1, 1'b0);
        add_row(CLS_HEBREW, 3'd2, 1'b0);
        add_row(CLS_EXTEND, 3'd3, 1'b0);
        add_row(CLS_MIDLETTER, 3'd1, 1'b0);
        add_row(CLS_EXTEND, 3'd2, 1'b0);
        add_row(CLS_LETTER, 3'd1, 1'b0);
        add_row(CLS_MIDNUM, 3'd1, 1'b0);
        // numbers with midnumlet, then midletter breaks, widest byte count
        add_row(CLS_NUMERIC, 3'd1, 1'b0);
        add_row(CLS_MIDNUMLET, 3'd1, 1'b0);
        add_row(CLS_NUMERIC, 3'd7, 1'b0);
        add_row(CLS_MIDLETTER, 3'd1, 1'b0);
        // katakana + extendnumlet + letter, zero byte count
        add_row(CLS_KATAKANA, 3'd2, 1'b0);
        add_row(CLS_EXTNUMLET, 3'd1, 1'b0);
        add_row(CLS_LETTER, 3'd0, 1'b0);
        // single alpha soaking extend, closed by an unknown class
        add_row(CLS_SINGLE, 3'd1, 1'b0);
        add_row(CLS_EXTEND, 3'd2, 1'b0);
        add_row(t_cls'(4'd15), 3'd5, 1'b0);
        // pending punctuation dropped at end of text
        add_row(CLS_LETTER, 3'd1, 1'b0);
        add_row(CLS_SQUOTE, 3'd6, 1'b1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_row(dir_rows[i]);

        // random text; pressure early, then a calm stretch
        while (sent_count < dir_rows.size() + RANDOM_ITEMS) begin
            if (sent_count >= dir_rows.size() + 300) hold_req <= 1'b1;
            calm <= (sent_count >= dir_rows.size() + 700 &&
                     sent_count <  dir_rows.size() + 1000);
            send_random_chunk();
        end
        in_if.valid <= 1'b0;
        calm        <= 1'b0;

        // drain, then keep watching for anything stray
        while (span_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: unicode_word_break_tokenizer.f
hdl/wbt_pkg.sv
hdl/wbt_if.sv
hdl/wbt_core.sv
hdl/wbt_fifo.sv
hdl/unicode_word_break_tokenizer.sv
tb/tb_top.sv
